/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the header parser checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ehtp_pkg.sv */
// ----------------------------------------------------------------------------
// ehtp_pkg
// Constants shared by the Ethernet / IPv4 / TCP header parser and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ehtp_pkg;

    localparam int ETH_HEADER_BYTES = 14;
    localparam int MAC_BYTES        = 6;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_NOT_IPV4  = 2'd0;
    localparam status_t STATUS_IPV4      = 2'd1;
    localparam status_t STATUS_TCP       = 2'd2;
    localparam status_t STATUS_TRUNCATED = 2'd3;

endpackage

`default_nettype wire

/* design/eth_ipv4_tcp_header_parser_top.sv */
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser_top
// Parses Ethernet, IPv4 and TCP header fields from a byte stream.
// ----------------------------------------------------------------------------
// The byte channel (byte_valid, byte_stall) carries one frame byte per word,
// with frame_end high on the last byte of a frame. The summary channel
// (summary_valid, summary_stall) carries one word per frame with the MAC
// addresses, the IPv4 and TCP fields, a status and a payload flag.
// A byte is taken into an input register, then its offset compare and
// field shift run combinationally and the summary lands in an output register.
// The last byte of a frame goes from the input register straight into the
// summary in the output register, unless that register is still stalled.
// The block takes one byte in every cycle while byte_stall is low. Only a frame's last byte can wait:
// it waits in the input register while a previous summary is stalled, and
// byte_stall then rises until the output register frees up.
// Reset clears the byte offset, all captured fields and both valid flags,
// so the next byte accepted is taken as the first byte of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eth_ipv4_tcp_header_parser_top
    import ehtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    output logic             summary_valid,
    input  wire logic        summary_stall,
    output logic [47:0]      dest_mac,
    output logic [47:0]      source_mac,
    output logic [1:0]       status,
    output logic [31:0]      source_ip,
    output logic [31:0]      dest_ip,
    output logic [5:0]       ip_header_bytes,
    output logic [15:0]      ip_total_length,
    output logic [15:0]      source_port,
    output logic [15:0]      dest_port,
    output logic [5:0]       tcp_header_bytes,
    output logic             has_payload
);

    localparam logic [7:0] OFS_SRC_MAC = 8'(MAC_BYTES);
    localparam logic [7:0] OFS_ETYPE   = 8'(2 * MAC_BYTES);
    localparam logic [7:0] OFS_IP      = 8'(ETH_HEADER_BYTES);
    localparam logic [7:0] OFS_TLEN_HI = 8'(ETH_HEADER_BYTES + 2);
    localparam logic [7:0] OFS_TLEN_LO = 8'(ETH_HEADER_BYTES + 3);
    localparam logic [7:0] OFS_PROTO   = 8'(ETH_HEADER_BYTES + 9);
    localparam logic [7:0] OFS_SRC_IP  = 8'(ETH_HEADER_BYTES + 12);
    localparam logic [7:0] OFS_DST_IP  = 8'(ETH_HEADER_BYTES + 16);
    localparam logic [7:0] OFS_IP_END  = 8'(ETH_HEADER_BYTES + 20);
    localparam logic [7:0] LAST_ETH    = 8'(ETH_HEADER_BYTES - 1);
    localparam logic [7:0] LAST_IP     = 8'(ETH_HEADER_BYTES + 19);
    localparam logic [7:0] LAST_TCP    = 8'(ETH_HEADER_BYTES + 12);
    localparam logic [7:0] OFS_MAX     = 8'hFF;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    logic [7:0]  offset_reg;
    logic [7:0]  offset_next;
    logic [47:0] dmac_acc_reg;
    logic [47:0] dmac_acc_next;
    logic [47:0] smac_acc_reg;
    logic [47:0] smac_acc_next;
    logic [15:0] etype_acc_reg;
    logic [15:0] etype_acc_next;
    logic [3:0]  ihl_reg;
    logic [3:0]  ihl_next;
    logic [15:0] tlen_acc_reg;
    logic [15:0] tlen_acc_next;
    logic [7:0]  proto_reg;
    logic [7:0]  proto_next;
    logic [31:0] sip_acc_reg;
    logic [31:0] sip_acc_next;
    logic [31:0] dip_acc_reg;
    logic [31:0] dip_acc_next;
    logic [15:0] sport_acc_reg;
    logic [15:0] sport_acc_next;
    logic [15:0] dport_acc_reg;
    logic [15:0] dport_acc_next;
    logic [3:0]  doff_reg;
    logic [3:0]  doff_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [47:0] dest_mac_reg;
    logic [47:0] source_mac_reg;
    status_t     status_reg;
    logic [31:0] source_ip_reg;
    logic [31:0] dest_ip_reg;
    logic [5:0]  ip_hdr_reg;
    logic [15:0] ip_tlen_reg;
    logic [15:0] source_port_reg;
    logic [15:0] dest_port_reg;
    logic [5:0]  tcp_hdr_reg;
    logic        payload_reg;

    logic        out_free;
    logic        advance;
    logic        in_accept;
    logic        emit;
    logic [7:0]  tcp_base;
    logic [7:0]  tcp_rel;
    logic        is_ipv4;
    logic        is_tcp;
    logic        truncated;
    logic [5:0]  ihl_bytes;
    logic [5:0]  doff_bytes;
    logic [6:0]  hdr_sum;
    status_t     status_next;

    assign out_free   = !out_valid_reg || !summary_stall;
    assign advance    = in_valid_reg && (!in_end_reg || out_free);
    assign byte_stall = in_valid_reg && !advance;
    assign in_accept  = byte_valid && !byte_stall;
    assign emit       = advance && in_end_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        offset_next    = (offset_reg == OFS_MAX) ? offset_reg : offset_reg + 8'd1;
        dmac_acc_next  = dmac_acc_reg;
        smac_acc_next  = smac_acc_reg;
        etype_acc_next = etype_acc_reg;
        ihl_next       = ihl_reg;
        tlen_acc_next  = tlen_acc_reg;
        proto_next     = proto_reg;
        sip_acc_next   = sip_acc_reg;
        dip_acc_next   = dip_acc_reg;
        sport_acc_next = sport_acc_reg;
        dport_acc_next = dport_acc_reg;
        doff_next      = doff_reg;

        if (offset_reg < OFS_SRC_MAC)
        begin
            dmac_acc_next = {dmac_acc_reg[39:0], in_byte_reg};
        end
        else if (offset_reg < OFS_ETYPE)
        begin
            smac_acc_next = {smac_acc_reg[39:0], in_byte_reg};
        end
        else if (offset_reg < OFS_IP)
        begin
            etype_acc_next = {etype_acc_reg[7:0], in_byte_reg};
        end

        if (offset_reg == OFS_IP)
        begin
            ihl_next = in_byte_reg[3:0];
        end
        else if (offset_reg == OFS_TLEN_HI || offset_reg == OFS_TLEN_LO)
        begin
            tlen_acc_next = {tlen_acc_reg[7:0], in_byte_reg};
        end
        else if (offset_reg == OFS_PROTO)
        begin
            proto_next = in_byte_reg;
        end
        else if (offset_reg >= OFS_SRC_IP && offset_reg < OFS_DST_IP)
        begin
            sip_acc_next = {sip_acc_reg[23:0], in_byte_reg};
        end
        else if (offset_reg >= OFS_DST_IP && offset_reg < OFS_IP_END)
        begin
            dip_acc_next = {dip_acc_reg[23:0], in_byte_reg};
        end

        if (offset_reg > OFS_IP && offset_reg >= tcp_base)
        begin
            if (tcp_rel < 8'd2)
            begin
                sport_acc_next = {sport_acc_reg[7:0], in_byte_reg};
            end
            else if (tcp_rel < 8'd4)
            begin
                dport_acc_next = {dport_acc_reg[7:0], in_byte_reg};
            end
            else if (tcp_rel == 8'd12)
            begin
                doff_next = in_byte_reg[7:4];
            end
        end
    end

    assign tcp_base = OFS_IP + {2'b00, ihl_reg, 2'b00};
    assign tcp_rel  = offset_reg - tcp_base;

    assign is_ipv4    = (etype_acc_next == ETYPE_IPV4);
    assign is_tcp     = is_ipv4 && (proto_next == PROTO_TCP);
    assign ihl_bytes  = {ihl_next, 2'b00};
    assign doff_bytes = {doff_next, 2'b00};
    assign hdr_sum    = {1'b0, ihl_bytes} + {1'b0, doff_bytes};
    assign truncated  = (offset_reg < LAST_ETH)
                     || (is_ipv4 && offset_reg < LAST_IP)
                     || (is_tcp && offset_reg < LAST_TCP + {2'b00, ihl_bytes});

    always_comb
    begin
        if (truncated)
        begin
            status_next = STATUS_TRUNCATED;
        end
        else if (is_tcp)
        begin
            status_next = STATUS_TCP;
        end
        else if (is_ipv4)
        begin
            status_next = STATUS_IPV4;
        end
        else
        begin
            status_next = STATUS_NOT_IPV4;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!summary_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
            in_end_reg  <= frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            dmac_acc_reg  <= '0;
            smac_acc_reg  <= '0;
            etype_acc_reg <= '0;
            ihl_reg       <= '0;
            tlen_acc_reg  <= '0;
            proto_reg     <= '0;
            sip_acc_reg   <= '0;
            dip_acc_reg   <= '0;
            sport_acc_reg <= '0;
            dport_acc_reg <= '0;
            doff_reg      <= '0;
        end
        else if (advance)
        begin
            if (in_end_reg)
            begin
                offset_reg    <= '0;
                dmac_acc_reg  <= '0;
                smac_acc_reg  <= '0;
                etype_acc_reg <= '0;
                ihl_reg       <= '0;
                tlen_acc_reg  <= '0;
                proto_reg     <= '0;
                sip_acc_reg   <= '0;
                dip_acc_reg   <= '0;
                sport_acc_reg <= '0;
                dport_acc_reg <= '0;
                doff_reg      <= '0;
            end
            else
            begin
                offset_reg    <= offset_next;
                dmac_acc_reg  <= dmac_acc_next;
                smac_acc_reg  <= smac_acc_next;
                etype_acc_reg <= etype_acc_next;
                ihl_reg       <= ihl_next;
                tlen_acc_reg  <= tlen_acc_next;
                proto_reg     <= proto_next;
                sip_acc_reg   <= sip_acc_next;
                dip_acc_reg   <= dip_acc_next;
                sport_acc_reg <= sport_acc_next;
                dport_acc_reg <= dport_acc_next;
                doff_reg      <= doff_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg      <= status_next;
            dest_mac_reg    <= truncated ? '0 : dmac_acc_next;
            source_mac_reg  <= truncated ? '0 : smac_acc_next;
            source_ip_reg   <= (!truncated && is_ipv4) ? sip_acc_next : '0;
            dest_ip_reg     <= (!truncated && is_ipv4) ? dip_acc_next : '0;
            ip_hdr_reg      <= (!truncated && is_ipv4) ? ihl_bytes : '0;
            ip_tlen_reg     <= (!truncated && is_ipv4) ? tlen_acc_next : '0;
            source_port_reg <= (!truncated && is_tcp) ? sport_acc_next : '0;
            dest_port_reg   <= (!truncated && is_tcp) ? dport_acc_next : '0;
            tcp_hdr_reg     <= (!truncated && is_tcp) ? doff_bytes : '0;
            payload_reg     <= !truncated && is_tcp && (tlen_acc_next > {9'd0, hdr_sum});
        end
    end

    assign summary_valid    = out_valid_reg;
    assign dest_mac         = dest_mac_reg;
    assign source_mac       = source_mac_reg;
    assign status           = status_reg;
    assign source_ip        = source_ip_reg;
    assign dest_ip          = dest_ip_reg;
    assign ip_header_bytes  = ip_hdr_reg;
    assign ip_total_length  = ip_tlen_reg;
    assign source_port      = source_port_reg;
    assign dest_port        = dest_port_reg;
    assign tcp_header_bytes = tcp_hdr_reg;
    assign has_payload      = payload_reg;

endmodule

`default_nettype wire

/* design/ehtp_checker.sv */
// ----------------------------------------------------------------------------
// ehtp_checker
// Port-level checks on the header parser byte and summary channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ehtp_checker
    import ehtp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        byte_stall,
    input wire logic [7:0]  data_byte,
    input wire logic        frame_end,
    input wire logic        summary_valid,
    input wire logic        summary_stall,
    input wire logic [47:0] dest_mac,
    input wire logic [47:0] source_mac,
    input wire logic [1:0]  status,
    input wire logic [31:0] source_ip,
    input wire logic [31:0] dest_ip,
    input wire logic [5:0]  ip_header_bytes,
    input wire logic [15:0] ip_total_length,
    input wire logic [15:0] source_port,
    input wire logic [15:0] dest_port,
    input wire logic [5:0]  tcp_header_bytes,
    input wire logic        has_payload
);

    `CHK_NEXT(a_byte_hold, clk, rst_n, byte_valid && byte_stall,
        byte_valid && $stable(data_byte) && $stable(frame_end),
        "A stalled byte word changed.")

    `CHK_NEXT(a_summary_hold, clk, rst_n, summary_valid && summary_stall,
        summary_valid && $stable(status) && $stable(dest_mac) && $stable(source_ip),
        "A stalled summary word changed.")

    `CHK_SAME(a_truncated_zero, clk, rst_n,
        summary_valid && status == STATUS_TRUNCATED,
        dest_mac == 48'd0 && source_mac == 48'd0 && source_ip == 32'd0
            && dest_ip == 32'd0 && ip_total_length == 16'd0 && source_port == 16'd0,
        "A truncated summary carries nonzero fields.")

    `CHK_SAME(a_not_tcp_zero, clk, rst_n,
        summary_valid && status != STATUS_TCP,
        source_port == 16'd0 && dest_port == 16'd0 && tcp_header_bytes == 6'd0
            && !has_payload,
        "A summary without TCP carries TCP fields.")

    `CHK_SAME(a_not_ipv4_zero, clk, rst_n,
        summary_valid && status == STATUS_NOT_IPV4,
        source_ip == 32'd0 && dest_ip == 32'd0 && ip_header_bytes == 6'd0
            && ip_total_length == 16'd0,
        "A non-IPv4 summary carries IPv4 fields.")

endmodule

bind eth_ipv4_tcp_header_parser_top ehtp_checker u_ehtp_checker (.*);

`default_nettype wire

/* sim/ehtp_summary_checker.sv */
// ----------------------------------------------------------------------------
// ehtp_summary_checker
// Watches the byte and summary channels of the header parser and checks them.
// ----------------------------------------------------------------------------
// Every accepted byte is fed to a local model of the parser. On the last byte
// of a frame the model queues the summary that the frame should produce. Each
// accepted summary is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehtp_summary_checker
    import ehtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic        byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    input  wire logic        summary_valid,
    input  wire logic        summary_stall,
    input  wire logic [47:0] dest_mac,
    input  wire logic [47:0] source_mac,
    input  wire logic [1:0]  status,
    input  wire logic [31:0] source_ip,
    input  wire logic [31:0] dest_ip,
    input  wire logic [5:0]  ip_header_bytes,
    input  wire logic [15:0] ip_total_length,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] dest_port,
    input  wire logic [5:0]  tcp_header_bytes,
    input  wire logic        has_payload,
    output int               error_count,
    output int               summaries_pending
);

    localparam int IP_TOTAL_LEN_OFS = 2;
    localparam int IP_PROTO_OFS     = 9;
    localparam int IP_SRC_OFS       = 12;
    localparam int IP_DST_OFS       = 16;
    localparam int IP_MIN_BYTES     = 20;
    localparam int TCP_DOFF_OFS     = 12;
    localparam int OFFSET_MAX       = 255;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        status_t     status;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [5:0]  ip_header_bytes;
        logic [15:0] ip_total_length;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [5:0]  tcp_header_bytes;
        logic        has_payload;
    } frame_summary_t;

    frame_summary_t expected_summaries[$];

    int          frame_pos;
    logic [47:0] dst_mac_sr;
    logic [47:0] src_mac_sr;
    logic [15:0] etype_sr;
    logic [3:0]  ihl_nib;
    logic [15:0] tot_len_sr;
    logic [7:0]  proto_byte;
    logic [31:0] src_ip_sr;
    logic [31:0] dst_ip_sr;
    logic [15:0] src_port_sr;
    logic [15:0] dst_port_sr;
    logic [3:0]  doff_nib;

    task automatic clear_frame();
        frame_pos   = 0;
        dst_mac_sr  = '0;
        src_mac_sr  = '0;
        etype_sr    = '0;
        ihl_nib     = '0;
        tot_len_sr  = '0;
        proto_byte  = '0;
        src_ip_sr   = '0;
        dst_ip_sr   = '0;
        src_port_sr = '0;
        dst_port_sr = '0;
        doff_nib    = '0;
    endtask

    task automatic report_error(input string line);
        $display("%0t: %s", $realtime, line);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int             o;
        int             n;
        int             tcp_base;
        int             rel;
        logic           ipv4;
        logic           tcp;
        frame_summary_t s;

        o = frame_pos;
        if (o < MAC_BYTES)
            dst_mac_sr = {dst_mac_sr[39:0], b};
        else if (o < 2 * MAC_BYTES)
            src_mac_sr = {src_mac_sr[39:0], b};
        else if (o < ETH_HEADER_BYTES)
            etype_sr = {etype_sr[7:0], b};

        if (o == ETH_HEADER_BYTES)
            ihl_nib = b[3:0];
        else if (o == ETH_HEADER_BYTES + IP_TOTAL_LEN_OFS
                 || o == ETH_HEADER_BYTES + IP_TOTAL_LEN_OFS + 1)
            tot_len_sr = {tot_len_sr[7:0], b};
        else if (o == ETH_HEADER_BYTES + IP_PROTO_OFS)
            proto_byte = b;
        else if (o >= ETH_HEADER_BYTES + IP_SRC_OFS && o < ETH_HEADER_BYTES + IP_DST_OFS)
            src_ip_sr = {src_ip_sr[23:0], b};
        else if (o >= ETH_HEADER_BYTES + IP_DST_OFS && o < ETH_HEADER_BYTES + IP_MIN_BYTES)
            dst_ip_sr = {dst_ip_sr[23:0], b};

        tcp_base = ETH_HEADER_BYTES + 4 * int'(ihl_nib);
        if (o > ETH_HEADER_BYTES && o >= tcp_base)
        begin
            rel = o - tcp_base;
            if (rel < 2)
                src_port_sr = {src_port_sr[7:0], b};
            else if (rel < 4)
                dst_port_sr = {dst_port_sr[7:0], b};
            else if (rel == TCP_DOFF_OFS)
                doff_nib = b[7:4];
        end

        if (frame_pos < OFFSET_MAX)
            frame_pos++;

        if (last)
        begin
            n    = o + 1;
            ipv4 = (etype_sr == ETYPE_IPV4);
            tcp  = ipv4 && (proto_byte == PROTO_TCP);
            s    = '0;
            if (n < ETH_HEADER_BYTES)
                s.status = STATUS_TRUNCATED;
            else if (ipv4 && n < ETH_HEADER_BYTES + IP_MIN_BYTES)
                s.status = STATUS_TRUNCATED;
            else if (tcp && n < tcp_base + TCP_DOFF_OFS + 1)
                s.status = STATUS_TRUNCATED;
            else if (tcp)
                s.status = STATUS_TCP;
            else if (ipv4)
                s.status = STATUS_IPV4;
            else
                s.status = STATUS_NOT_IPV4;

            if (s.status != STATUS_TRUNCATED)
            begin
                s.dest_mac   = dst_mac_sr;
                s.source_mac = src_mac_sr;
                if (ipv4)
                begin
                    s.source_ip       = src_ip_sr;
                    s.dest_ip         = dst_ip_sr;
                    s.ip_header_bytes = {ihl_nib, 2'b00};
                    s.ip_total_length = tot_len_sr;
                end
                if (tcp)
                begin
                    s.source_port      = src_port_sr;
                    s.dest_port        = dst_port_sr;
                    s.tcp_header_bytes = {doff_nib, 2'b00};
                    s.has_payload      = int'(tot_len_sr) > 4 * int'(ihl_nib) + 4 * int'(doff_nib);
                end
            end
            expected_summaries.push_back(s);
            clear_frame();
        end
    endtask

    task automatic check_summary();
        frame_summary_t want;

        if (expected_summaries.size() == 0)
        begin
            report_error("summary word arrived with no frame outstanding");
        end
        else
        begin
            want = expected_summaries.pop_front();
            check_field("dest_mac", dest_mac, want.dest_mac);
            check_field("source_mac", source_mac, want.source_mac);
            check_field("status", status, want.status);
            check_field("source_ip", source_ip, want.source_ip);
            check_field("dest_ip", dest_ip, want.dest_ip);
            check_field("ip_header_bytes", ip_header_bytes, want.ip_header_bytes);
            check_field("ip_total_length", ip_total_length, want.ip_total_length);
            check_field("source_port", source_port, want.source_port);
            check_field("dest_port", dest_port, want.dest_port);
            check_field("tcp_header_bytes", tcp_header_bytes, want.tcp_header_bytes);
            check_field("has_payload", has_payload, want.has_payload);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            expected_summaries.delete();
            summaries_pending = 0;
            error_count       = 0;
        end
        else
        begin
            if (summary_valid && !summary_stall)
                check_summary();
            if (byte_valid && !byte_stall)
                absorb_byte(data_byte, frame_end);
            summaries_pending = expected_summaries.size();
        end
    end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Ethernet / IPv4 / TCP header parser.
// ----------------------------------------------------------------------------
// Frames are sent one byte per word: first a directed set covering short and
// truncated frames, extreme header lengths, the payload boundary and a frame
// longer than the offset counter, then random frames, about half of them complete TCP frames.
// Four pacing phases vary sender gaps and receiver stalls. A checker module
// beside the parser predicts and compares every summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ehtp_pkg::*;

    localparam int          ETYPE_AT       = 2 * MAC_BYTES;
    localparam int          TOTAL_LEN_AT   = ETH_HEADER_BYTES + 2;
    localparam int          PROTO_AT       = ETH_HEADER_BYTES + 9;
    localparam int          IP_MIN_BYTES   = 20;
    localparam int          TCP_DOFF_REL   = 12;
    localparam logic [7:0]  PROTO_UDP      = 8'h11;
    localparam int          ITEMS          = 1950;
    localparam int          PHASES         = 4;
    localparam int          FRAMES_MIN     = 4;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        summary_valid;
    logic        summary_stall = 1'b0;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [1:0]  status;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [5:0]  ip_header_bytes;
    logic [15:0] ip_total_length;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0]  tcp_header_bytes;
    logic        has_payload;

    int          error_count;
    int          summaries_pending;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          idle_cycles = 0;
    int          sent_bytes = 0;
    int          phase_frames;
    logic [7:0]  frame_buf[$];

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    eth_ipv4_tcp_header_parser_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (byte_valid),
        .byte_stall       (byte_stall),
        .data_byte        (data_byte),
        .frame_end        (frame_end),
        .summary_valid    (summary_valid),
        .summary_stall    (summary_stall),
        .dest_mac         (dest_mac),
        .source_mac       (source_mac),
        .status           (status),
        .source_ip        (source_ip),
        .dest_ip          (dest_ip),
        .ip_header_bytes  (ip_header_bytes),
        .ip_total_length  (ip_total_length),
        .source_port      (source_port),
        .dest_port        (dest_port),
        .tcp_header_bytes (tcp_header_bytes),
        .has_payload      (has_payload)
    );

    ehtp_summary_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .data_byte         (data_byte),
        .frame_end         (frame_end),
        .summary_valid     (summary_valid),
        .summary_stall     (summary_stall),
        .dest_mac          (dest_mac),
        .source_mac        (source_mac),
        .status            (status),
        .source_ip         (source_ip),
        .dest_ip           (dest_ip),
        .ip_header_bytes   (ip_header_bytes),
        .ip_total_length   (ip_total_length),
        .source_port       (source_port),
        .dest_port         (dest_port),
        .tcp_header_bytes  (tcp_header_bytes),
        .has_payload       (has_payload),
        .error_count       (error_count),
        .summaries_pending (summaries_pending)
    );

    always @(posedge clk)
    begin
        summary_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (summary_valid && !summary_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= value;
        frame_end  <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        sent_bytes += frame_buf.size();
        phase_frames++;
    endtask

    task automatic fill_frame(input int len, input bit rand_fill, input logic [7:0] value);
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.push_back(rand_fill ? 8'($urandom) : value);
    endtask

    task automatic stamp_headers(input logic [15:0] etype, input logic [7:0] vihl,
                                 input logic [15:0] tlen, input logic [7:0] proto,
                                 input logic [7:0] doff_byte);
        int doff_at;

        doff_at = ETH_HEADER_BYTES + 4 * int'(vihl[3:0]) + TCP_DOFF_REL;
        if (frame_buf.size() > ETYPE_AT + 1)
        begin
            frame_buf[ETYPE_AT]     = etype[15:8];
            frame_buf[ETYPE_AT + 1] = etype[7:0];
        end
        if (frame_buf.size() > ETH_HEADER_BYTES)
            frame_buf[ETH_HEADER_BYTES] = vihl;
        if (frame_buf.size() > TOTAL_LEN_AT + 1)
        begin
            frame_buf[TOTAL_LEN_AT]     = tlen[15:8];
            frame_buf[TOTAL_LEN_AT + 1] = tlen[7:0];
        end
        if (frame_buf.size() > PROTO_AT)
            frame_buf[PROTO_AT] = proto;
        if (frame_buf.size() > doff_at)
            frame_buf[doff_at] = doff_byte;
    endtask

    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (summaries_pending != 0);
    endtask

    task automatic send_directed_frames();
        fill_frame(1, 1'b0, 8'hFF);
        send_frame();
        fill_frame(13, 1'b0, 8'hFF);
        send_frame();
        fill_frame(14, 1'b0, 8'h00);
        send_frame();
        fill_frame(14, 1'b0, 8'hFF);
        send_frame();
        fill_frame(33, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h45, 16'd60, PROTO_UDP, 8'h50);
        send_frame();
        fill_frame(34, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h45, 16'hFFFF, PROTO_UDP, 8'h50);
        send_frame();
        fill_frame(34, 1'b0, 8'hFF);
        stamp_headers(ETYPE_IPV4, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_frame();
        fill_frame(54, 1'b0, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h00);
        send_frame();
        fill_frame(54, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 8'h50);
        send_frame();
        fill_frame(54, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h45, 16'd41, PROTO_TCP, 8'h5F);
        send_frame();
        fill_frame(86, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h4F, 16'hFFFF, PROTO_TCP, 8'hF0);
        send_frame();
        fill_frame(87, 1'b0, 8'hFF);
        stamp_headers(ETYPE_IPV4, 8'hFF, 16'hFFFF, PROTO_TCP, 8'hFF);
        send_frame();
        fill_frame(40, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h40, 16'd8, PROTO_TCP, 8'h20);
        send_frame();
        fill_frame(40, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h41, 16'd30, PROTO_TCP, 8'h50);
        send_frame();
        fill_frame(34, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h42, 16'd30, PROTO_TCP, 8'h50);
        send_frame();
        fill_frame(60, 1'b1, 8'h00);
        stamp_headers(16'h0801, 8'h45, 16'd46, PROTO_TCP, 8'h50);
        send_frame();
        fill_frame(300, 1'b1, 8'h00);
        stamp_headers(ETYPE_IPV4, 8'h45, 16'd1000, PROTO_TCP, 8'h80);
        send_frame();
    endtask

    task automatic send_random_frame();
        int          ihl;
        int          doff;
        int          full_min;
        int          pick;
        int          len;
        logic [15:0] etype;
        logic [15:0] tlen;
        logic [7:0]  vihl;
        logic [7:0]  proto;

        ihl  = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
        doff = $urandom_range(15);
        full_min = ETH_HEADER_BYTES + 4 * ihl + TCP_DOFF_REL + 1;
        if (full_min < ETH_HEADER_BYTES + IP_MIN_BYTES)
            full_min = ETH_HEADER_BYTES + IP_MIN_BYTES;
        vihl = {4'($urandom_range(15)), 4'(ihl)};
        if ($urandom_range(1) == 0)
            tlen = 16'(4 * ihl + 4 * doff + $urandom_range(2)) - 16'd1;
        else
            tlen = 16'($urandom);
        etype = ETYPE_IPV4;
        proto = PROTO_TCP;
        pick  = $urandom_range(99);
        if (pick < 50)
        begin
            len = ($urandom_range(49) == 0) ? $urandom_range(320, 256)
                                            : full_min + $urandom_range(24);
        end
        else if (pick < 62)
        begin
            len = $urandom_range(full_min - 1, ETH_HEADER_BYTES);
        end
        else if (pick < 77)
        begin
            len   = $urandom_range(70, IP_MIN_BYTES);
            proto = 8'($urandom);
            if (proto == PROTO_TCP)
                proto = PROTO_UDP;
        end
        else if (pick < 90)
        begin
            len = $urandom_range(60, 1);
            if ($urandom_range(1) == 0)
                etype = 16'($urandom);
            else
                etype = ETYPE_IPV4 ^ (16'd1 << $urandom_range(15));
            if (etype == ETYPE_IPV4)
                etype = ~etype;
        end
        else
        begin
            len = $urandom_range(40, 1);
        end
        fill_frame(len, 1'b1, 8'h00);
        if (pick < 90)
            stamp_headers(etype, vihl, tlen, proto, {4'(doff), 4'($urandom_range(15))});
        send_frame();
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 48;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 48;
                end
                default:
                begin
                    sender_idle_pct    = 14;
                    receiver_stall_pct = 14;
                end
            endcase
            phase_frames = 0;
            if (phase == 0)
                send_directed_frames();
            while (sent_bytes < (phase + 1) * (ITEMS / PHASES) || phase_frames < FRAMES_MIN)
            begin
                send_random_frame();
                if ($urandom_range(19) == 0)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
        if (error_count == 0 && summaries_pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
